/* hdl/event_driven_cosine_speed_profiler_unit_assert.svh */
// Assertion macros for the cosine speed profiler checker.
// Expects signals clk and rst_n in the scope of use.
`ifndef EVENT_DRIVEN_COSINE_SPEED_PROFILER_UNIT_ASSERT_SVH
`define EVENT_DRIVEN_COSINE_SPEED_PROFILER_UNIT_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define ECSP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecsp: assertion failed");

// ante holds -> cons holds in the next cycle
`define ECSP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecsp: assertion failed");

// state after a reset edge
`define ECSP_ASSERT_RST(name, cons) \
  name: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("ecsp: reset assertion failed");

`endif

/* hdl/ecsp_pkg.sv */
// Shared types, constants, cosine table and helpers for the speed profiler.
// No dependencies.
package ecsp_pkg;

  localparam int SPEED_W      = 16;
  localparam int PHASE_W      = 17;
  localparam int PHASE_FRAC_W = 16;
  localparam int CNT_W        = 16;
  localparam int TASK_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [PHASE_W-1:0] PHASE_PI = PHASE_W'(1) << PHASE_FRAC_W;
  localparam logic [CNT_W-1:0]   CNT_MAX  = '1;

  localparam int COS_TABLE_ENTRIES = 256;
  localparam int COS_IDX_W         = $clog2(COS_TABLE_ENTRIES);

  localparam logic [TASK_W-1:0] TASK_CLEAR   = 3'd0;
  localparam logic [TASK_W-1:0] TASK_BOX     = 3'd1;
  localparam logic [TASK_W-1:0] TASK_UNKNOWN = 3'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_WAIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_WAIT  = 3'd5;

  localparam logic [SPEED_W-1:0] RST_CRUISE     = 16'd1000;
  localparam logic [SPEED_W-1:0] RST_BOX        = 16'd500;
  localparam logic [SPEED_W-1:0] RST_UNKNOWN    = 16'd500;
  localparam logic [PHASE_FRAC_W-1:0] RST_STEP  = 16'd1024;
  localparam logic [CNT_W-1:0]   RST_STOP_WAIT  = 16'd100;
  localparam logic [CNT_W-1:0]   RST_ROBOT_WAIT = 16'd100;

  localparam longint          Q30_ONE = 64'sd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  typedef struct packed {
    logic [SPEED_W-1:0]      cruise_speed;
    logic [SPEED_W-1:0]      box_speed;
    logic [SPEED_W-1:0]      unknown_area_speed;
    logic [PHASE_FRAC_W-1:0] ramp_phase_step;
    logic [CNT_W-1:0]        stop_wait_ticks;
    logic [CNT_W-1:0]        robot_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic              stop_seen;
    logic              robot_seen;
    logic [TASK_W-1:0] task_code;
  } tick_t;

  typedef struct packed {
    logic  valid;
    tick_t tick;
  } stage_t;

  typedef logic [PHASE_W-1:0] cos_tab_t [COS_TABLE_ENTRIES];

  // (1+cos)/2 over a half period, Q16, via a Q30 Taylor series for cos(x/2)
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t        tab;
    longint unsigned t;
    longint          u;
    longint          x;
    int              k;
    for (k = 0; k < COS_TABLE_ENTRIES; k++) begin
      t = (PI_Q30 * longint'(k)) / (2 * COS_TABLE_ENTRIES);
      u = longint'((t * t) >> 30);
      x = Q30_ONE;
      x = Q30_ONE - longint'(longint'(unsigned'((u * x) / 182)) >>> 30); if (x < 0) x = 0;
      x = Q30_ONE - longint'(longint'(unsigned'((u * x) / 132)) >>> 30); if (x < 0) x = 0;
      x = Q30_ONE - longint'(longint'(unsigned'((u * x) / 90)) >>> 30);  if (x < 0) x = 0;
      x = Q30_ONE - longint'(longint'(unsigned'((u * x) / 56)) >>> 30);  if (x < 0) x = 0;
      x = Q30_ONE - longint'(longint'(unsigned'((u * x) / 30)) >>> 30);  if (x < 0) x = 0;
      x = Q30_ONE - longint'(longint'(unsigned'((u * x) / 12)) >>> 30);  if (x < 0) x = 0;
      x = Q30_ONE - longint'(longint'(unsigned'((u * x) / 2)) >>> 30);   if (x < 0) x = 0;
      t = longint'(x);
      tab[k] = PHASE_W'(((t * t) + (64'd1 << 43)) >> 44);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

  function automatic logic [PHASE_W-1:0] phase_add(input logic [PHASE_W-1:0] p,
                                                   input logic [PHASE_FRAC_W-1:0] step);
    logic [PHASE_W:0] s;
    s = {1'b0, p} + (PHASE_W + 1)'(step);
    return (s > (PHASE_W + 1)'(PHASE_PI)) ? PHASE_PI : s[PHASE_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    return (c < CNT_MAX) ? c + CNT_W'(1) : c;
  endfunction

endpackage

/* hdl/ecsp_if.sv */
// Stream interfaces for the tick words and the speed words.
// Depends on ecsp_pkg.
interface ecsp_in_if import ecsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              stop_seen;
  logic              robot_seen;
  logic [TASK_W-1:0] task_code;

  modport source(output valid, stop_seen, robot_seen, task_code, input ready);
  modport sink(input valid, stop_seen, robot_seen, task_code, output ready);
endinterface

interface ecsp_out_if import ecsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_command;

  modport source(output valid, speed_command, input ready);
  modport sink(input valid, speed_command, output ready);
endinterface

/* hdl/ecsp_cfg_regs.sv */
// Configuration register file, written through a plain write port.
// Depends on ecsp_pkg.
module ecsp_cfg_regs import ecsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CRUISE:     cfg_nxt.cruise_speed       = cfg_wdata;
        CFG_BOX:        cfg_nxt.box_speed          = cfg_wdata;
        CFG_UNKNOWN:    cfg_nxt.unknown_area_speed = cfg_wdata;
        CFG_PHASE_STEP: cfg_nxt.ramp_phase_step    = cfg_wdata;
        CFG_STOP_WAIT:  cfg_nxt.stop_wait_ticks    = cfg_wdata;
        CFG_ROBOT_WAIT: cfg_nxt.robot_wait_ticks   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cruise_speed       <= RST_CRUISE;
      cfg_r.box_speed          <= RST_BOX;
      cfg_r.unknown_area_speed <= RST_UNKNOWN;
      cfg_r.ramp_phase_step    <= RST_STEP;
      cfg_r.stop_wait_ticks    <= RST_STOP_WAIT;
      cfg_r.robot_wait_ticks   <= RST_ROBOT_WAIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/ecsp_in_stage.sv */
// Input register for one tick word, released when the core takes it.
// Depends on ecsp_pkg.
module ecsp_in_stage import ecsp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  tick_t  in_tick,
  input  logic   take,
  output stage_t stage
);

  logic  valid_r;
  logic  valid_nxt;
  tick_t tick_r;
  logic  accept;

  assign in_ready = !valid_r || take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick_r <= in_tick;
    end
  end

  assign stage.valid = valid_r;
  assign stage.tick  = tick_r;

endmodule

/* hdl/ecsp_cos_weight.sv */
// Phase to raised-cosine weight lookup, Q16 weight from a Q16 phase.
// Depends on ecsp_pkg (COS_TAB).
module ecsp_cos_weight import ecsp_pkg::*; (
  input  logic [PHASE_W-1:0] phase,
  output logic [PHASE_W-1:0] weight
);

  localparam int PROD_W = PHASE_W + COS_IDX_W + 1;
  localparam int FULL_W = PROD_W - PHASE_FRAC_W;

  logic [PROD_W-1:0]    prod;
  logic [FULL_W-1:0]    idx_full;
  logic [COS_IDX_W-1:0] idx;

  assign prod     = PROD_W'(phase) * PROD_W'(COS_TABLE_ENTRIES);
  assign idx_full = prod[PROD_W-1:PHASE_FRAC_W];
  assign idx      = (idx_full >= FULL_W'(COS_TABLE_ENTRIES)) ?
                    COS_IDX_W'(COS_TABLE_ENTRIES - 1) : idx_full[COS_IDX_W-1:0];
  assign weight   = COS_TAB[idx];

endmodule

/* hdl/ecsp_core.sv */
// Profiler state and speed update, one tick word per cycle into the result register unless the speed word stalls.
// Depends on ecsp_pkg and ecsp_cos_weight.
module ecsp_core import ecsp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  stage_t             stage,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SPEED_W-1:0] speed_command
);

  logic sl_r, sl_nxt, srd_r, srd_nxt, gl_r, gl_nxt, rl_r, rl_nxt;
  logic rrd_r, rrd_nxt, brd_r, brd_nxt, urd_r, urd_nxt;
  logic [PHASE_W-1:0] bp_r, bp_nxt, tp_r, tp_nxt;
  logic [CNT_W-1:0]   swc_r, swc_nxt, rac_r, rac_nxt;
  logic [SPEED_W-1:0] held_speed_r, vel;
  logic               out_valid_r;

  logic               stop, robot;
  logic [TASK_W-1:0]  task_code;
  logic [PHASE_W-1:0] bp_adv, tp_adv, bp_fin, wb, wt;
  logic [CNT_W-1:0]   swc_adv, rac_adv;
  logic               stop_clear;
  logic [SPEED_W-1:0] target, diff, brake_vel, task_vel;
  logic [32:0]        brake_prod, task_prod;
  logic [33:0]        brake_rnd, task_rnd;

  assign stop      = stage.tick.stop_seen;
  assign robot     = stage.tick.robot_seen;
  assign task_code = stage.tick.task_code;
  assign take      = stage.valid && (!out_valid_r || out_ready);

  assign bp_adv  = phase_add(bp_r, cfg.ramp_phase_step);
  assign tp_adv  = phase_add(tp_r, cfg.ramp_phase_step);
  assign swc_adv = cnt_inc(swc_r);
  assign rac_adv = cnt_inc(rac_r);

  // brake phase after a possible ramp start
  always_comb begin
    stop_clear = !stop && srd_r && (swc_adv >= cfg.stop_wait_ticks);
    if (robot) begin
      bp_fin = rl_r ? bp_adv : '0;
    end else begin
      bp_fin = (stop && !(sl_r && !stop_clear)) ? '0 : bp_adv;
    end
  end

  ecsp_cos_weight u_brake_w (.phase(bp_fin), .weight(wb));
  ecsp_cos_weight u_task_w  (.phase(tp_adv), .weight(wt));

  assign brake_prod = 33'(cfg.cruise_speed) * 33'(wb);
  assign brake_rnd  = 34'(brake_prod) + 34'd32768;
  assign brake_vel  = brake_rnd[31:16];

  assign target    = (task_code == TASK_UNKNOWN) ? cfg.unknown_area_speed : cfg.box_speed;
  assign diff      = (cfg.cruise_speed >= target) ? cfg.cruise_speed - target
                                                  : target - cfg.cruise_speed;
  assign task_prod = 33'(diff) * 33'(wt);
  assign task_rnd  = 34'(task_prod) + 34'd32768;
  assign task_vel  = (cfg.cruise_speed >= target) ? target + task_rnd[31:16]
                                                  : target - task_rnd[31:16];

  always_comb begin
    sl_nxt  = sl_r;
    srd_nxt = srd_r;
    gl_nxt  = gl_r;
    rl_nxt  = rl_r;
    rrd_nxt = rrd_r;
    brd_nxt = brd_r;
    urd_nxt = urd_r;
    bp_nxt  = bp_fin;
    tp_nxt  = tp_adv;
    swc_nxt = swc_adv;
    rac_nxt = rac_adv;
    vel     = cfg.cruise_speed;

    if (!robot) begin
      if (stop_clear) begin
        sl_nxt  = 1'b0;
        srd_nxt = 1'b0;
      end
      if (stop && !sl_nxt) begin
        sl_nxt = 1'b1;
      end
      if (sl_nxt) begin
        if (!srd_nxt) begin
          if (bp_fin < PHASE_PI) begin
            vel = brake_vel;
          end else begin
            vel     = '0;
            swc_nxt = '0;
            srd_nxt = 1'b1;
          end
        end else begin
          vel = (swc_adv < cfg.stop_wait_ticks) ? '0 : cfg.cruise_speed;
        end
      end
      if (!gl_r) begin
        rac_nxt = '0;
        gl_nxt  = 1'b1;
      end
      if (rac_nxt > cfg.robot_wait_ticks) begin
        rl_nxt  = 1'b0;
        rrd_nxt = 1'b0;
      end
    end else begin
      gl_nxt = 1'b0;
      rl_nxt = 1'b1;
      if (!rrd_r) begin
        if (bp_fin < PHASE_PI) begin
          vel = brake_vel;
        end else begin
          vel     = '0;
          rrd_nxt = 1'b1;
        end
      end else begin
        vel = '0;
      end
    end

    case (task_code)
      TASK_CLEAR: begin
        brd_nxt = 1'b0;
        urd_nxt = 1'b0;
        tp_nxt  = '0;
      end
      TASK_BOX: begin
        if (!brd_r && tp_adv < PHASE_PI) begin
          vel = task_vel;
        end else begin
          vel     = cfg.box_speed;
          brd_nxt = 1'b1;
        end
      end
      TASK_UNKNOWN: begin
        if (!urd_r && tp_adv < PHASE_PI) begin
          vel = task_vel;
        end else begin
          vel     = cfg.unknown_area_speed;
          urd_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sl_r         <= 1'b0;
      srd_r        <= 1'b0;
      gl_r         <= 1'b0;
      rl_r         <= 1'b0;
      rrd_r        <= 1'b0;
      brd_r        <= 1'b0;
      urd_r        <= 1'b0;
      bp_r         <= '0;
      tp_r         <= '0;
      swc_r        <= '0;
      rac_r        <= '0;
      held_speed_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        sl_r         <= sl_nxt;
        srd_r        <= srd_nxt;
        gl_r         <= gl_nxt;
        rl_r         <= rl_nxt;
        rrd_r        <= rrd_nxt;
        brd_r        <= brd_nxt;
        urd_r        <= urd_nxt;
        bp_r         <= bp_nxt;
        tp_r         <= tp_nxt;
        swc_r        <= swc_nxt;
        rac_r        <= rac_nxt;
        held_speed_r <= vel;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign speed_command = held_speed_r;

endmodule

/* hdl/event_driven_cosine_speed_profiler_unit.sv */
// Channel   | dir | payload                                  | handshake
// in_ch     | in  | stop_seen, robot_seen, task_code[2:0]    | valid/ready
// out_ch    | out | speed_command[15:0]                      | valid/ready
// cfg_*     | in  | cfg_index[2:0], cfg_wdata[15:0]          | cfg_we, no wait
//
// One tick word per cycle sustained while speed words are taken; each tick word passes
// through the input register, then the table lookup and one multiply per ramp into
// the result register. Synchronous active-low reset clears the profiler state and
// loads the register defaults. A stalled speed word holds; one more tick word waits
// in the input register, then in_ch.ready drops until the speed word is taken.
// Depends on ecsp_pkg, ecsp_if, ecsp_cfg_regs, ecsp_in_stage, ecsp_core.
module event_driven_cosine_speed_profiler_unit import ecsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ecsp_in_if.sink               in_ch,
  ecsp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg;
  tick_t  in_tick;
  stage_t stage;
  logic   take;

  assign in_tick.stop_seen  = in_ch.stop_seen;
  assign in_tick.robot_seen = in_ch.robot_seen;
  assign in_tick.task_code  = in_ch.task_code;

  ecsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ecsp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_tick  (in_tick),
    .take     (take),
    .stage    (stage)
  );

  ecsp_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .stage         (stage),
    .take          (take),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .speed_command (out_ch.speed_command)
  );

endmodule

/* hdl/ecsp_checker.sv */
// Port-level checks for the speed profiler, bound to the top level.
// Depends on ecsp_pkg and event_driven_cosine_speed_profiler_unit_assert.svh.
`include "event_driven_cosine_speed_profiler_unit_assert.svh"

module ecsp_checker import ecsp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SPEED_W-1:0] speed_command
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  `ECSP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(speed_command))
  // input only backs up behind a stalled speed word
  `ECSP_ASSERT_IMP(a_backpressure, !in_ready, out_valid && !out_ready)
  `ECSP_ASSERT_IMP(a_latency, in_acc, ##2 out_valid)
  `ECSP_ASSERT_RST(a_reset_empty, !out_valid && in_ready)

endmodule

bind event_driven_cosine_speed_profiler_unit ecsp_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .speed_command (out_ch.speed_command)
);
